// ----- src/linear_interp_resampler_assert.svh -----
// assertion macros shared by the resampler modules
`ifndef LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define LIR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define LIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lir_pkg.sv -----
// shared constants and controller/datapath interface types for the resampler
`default_nettype none

package lir_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RATE_W   = 18;
  localparam int unsigned NUM_W    = 36;

  // q16 constants
  localparam logic [RATE_W-1:0] Q_ONE        = 18'd65536;
  localparam logic [RATE_W:0]   Q_TWO        = 19'd131072;
  localparam logic [RATE_W-1:0] RATE_OFF_MAX = 18'd655;
  localparam logic [RATE_W-1:0] RATE_LOW     = 18'd2048;
  localparam logic [RATE_W-1:0] RATE_HIGH    = 18'd131072;

  // saturation limits of the output sample
  localparam logic signed [19:0] SAT_POS = 20'sd32767;
  localparam logic signed [19:0] SAT_NEG = -20'sd32768;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic start_chunk;
    logic skip;
    logic step_done;
    logic mul;
    logic round;
    logic flush;
    logic echo;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic first_pending;
    logic chunk_off;
    logic last;
    logic cfg_off;
    logic loop_go;
    logic next_go;
    logic need_push;
    logic held_valid;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- src/lir_ctrl.sv -----
// controller state machine sequencing one input item through the datapath
`default_nettype none
`include "linear_interp_resampler_assert.svh"

module lir_ctrl import lir_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MUL,
    S_ROUND,
    S_FLUSH,
    S_ECHO
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.first_pending) begin
          cmd_o.start_chunk = 1'b1;
          state_d = (sts_i.last && !sts_i.cfg_off) ? S_ECHO : S_IDLE;
        end else if (sts_i.chunk_off) begin
          cmd_o.skip = 1'b1;
          state_d    = S_IDLE;
        end else if (sts_i.loop_go) begin
          state_d = S_MUL;
        end else if (sts_i.last) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.step_done = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ROUND;
      end
      S_ROUND: begin
        if (!sts_i.need_push || sts_i.out_free) begin
          cmd_o.round = 1'b1;
          state_d     = sts_i.next_go ? S_MUL : S_DECIDE;
        end
      end
      S_FLUSH: begin
        if (!sts_i.held_valid || sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_ECHO: begin
        if (sts_i.out_free) begin
          cmd_o.echo = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = in_ready_q;

  `LIR_ASSERT_NOW(a_ready_idle, in_ready_q, state_q == S_IDLE, "ready outside idle")
  `LIR_ASSERT_NEXT(a_mul_round, state_q == S_MUL, state_q == S_ROUND, "mul not followed by round")
  `LIR_ASSERT_NEXT(a_round_hold, (state_q == S_ROUND) && !cmd_o.round, state_q == S_ROUND,
                   "stalled round left its state")

endmodule

`default_nettype wire

// ----- src/lir_dpath.sv -----
// datapath: chunk state, interpolation multiply, rounding, hold stage and output register
`default_nettype none
`include "linear_interp_resampler_assert.svh"

module lir_dpath import lir_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic        [RATE_W-1:0]   rate_q16_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_in_i,
  input  wire logic                       last_in_i,
  input  wire cmd_t                       cmd_i,
  output sts_t                            sts_o,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic signed [SAMPLE_W-1:0]      sample_out_o,
  output logic                            last_out_o
);

  logic        [RATE_W-1:0]   rate_cfg_q;
  logic        [RATE_W-1:0]   chunk_rate_q;
  logic                       chunk_off_q;
  logic                       first_pending_q;
  logic        [RATE_W-1:0]   phase_q;
  logic signed [SAMPLE_W-1:0] prev_q;
  logic                       held_valid_q;
  logic signed [SAMPLE_W-1:0] held_value_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       last_q;
  logic signed [NUM_W-1:0]    num_q;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                       out_last_q;

  logic        [RATE_W-1:0]   rate_clamp;
  logic        [RATE_W:0]     sum_pr;
  logic        [RATE_W:0]     sum_prr;
  logic                       delay;
  logic                       out_free;
  logic signed [16:0]         diff;
  logic signed [18:0]         frac_s;
  logic signed [NUM_W-1:0]    base;
  logic signed [NUM_W-1:0]    prod;
  logic signed [19:0]         q_floor;
  logic signed [19:0]         q_trunc;
  logic                       round_up;
  logic signed [SAMPLE_W-1:0] interp_v;
  logic                       push;
  logic signed [SAMPLE_W-1:0] push_val;
  logic                       push_last;

  // rate clamp for a new chunk
  always_comb begin
    if (rate_cfg_q < RATE_LOW) begin
      rate_clamp = RATE_LOW;
    end else if (rate_cfg_q > RATE_HIGH) begin
      rate_clamp = RATE_HIGH;
    end else begin
      rate_clamp = rate_cfg_q;
    end
  end

  // loop conditions on the current and the next position
  assign sum_pr  = {1'b0, phase_q} + {1'b0, chunk_rate_q};
  assign sum_prr = sum_pr + {1'b0, chunk_rate_q};
  assign delay   = last_q || (chunk_rate_q > Q_ONE);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.first_pending = first_pending_q;
    sts_o.chunk_off     = chunk_off_q;
    sts_o.last          = last_q;
    sts_o.cfg_off       = (rate_cfg_q <= RATE_OFF_MAX);
    sts_o.loop_go       = last_q ? (sum_pr <= Q_TWO) : (phase_q < Q_ONE);
    sts_o.next_go       = last_q ? (sum_prr <= Q_TWO) : (sum_pr < {1'b0, Q_ONE});
    sts_o.need_push     = delay ? held_valid_q : 1'b1;
    sts_o.held_valid    = held_valid_q;
    sts_o.out_free      = out_free;
  end

  // interpolation numerator: a*65536 + (b - a)*f
  assign diff   = {sample_q[SAMPLE_W-1], sample_q} - {prev_q[SAMPLE_W-1], prev_q};
  assign frac_s = {1'b0, phase_q};
  assign base   = {{4{prev_q[SAMPLE_W-1]}}, prev_q, 16'd0};
  assign prod   = diff * frac_s;

  // divide by 65536 toward zero, then saturate
  assign q_floor  = num_q[NUM_W-1:16];
  assign round_up = num_q[NUM_W-1] && (|num_q[15:0]);
  assign q_trunc  = q_floor + {19'd0, round_up};

  always_comb begin
    if (q_trunc > SAT_POS) begin
      interp_v = SAT_POS[SAMPLE_W-1:0];
    end else if (q_trunc < SAT_NEG) begin
      interp_v = SAT_NEG[SAMPLE_W-1:0];
    end else begin
      interp_v = q_trunc[SAMPLE_W-1:0];
    end
  end

  // choose what goes to the output register
  always_comb begin
    push      = 1'b0;
    push_val  = held_value_q;
    push_last = 1'b0;
    if (cmd_i.round) begin
      if (delay) begin
        push = held_valid_q;
      end else begin
        push     = 1'b1;
        push_val = interp_v;
      end
    end
    if (cmd_i.flush) begin
      push      = held_valid_q;
      push_last = 1'b1;
    end
    if (cmd_i.echo) begin
      push      = 1'b1;
      push_val  = sample_q;
      push_last = 1'b1;
    end
  end

  // chunk control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_cfg_q      <= Q_ONE;
      chunk_rate_q    <= Q_ONE;
      chunk_off_q     <= 1'b0;
      first_pending_q <= 1'b1;
      phase_q         <= '0;
      prev_q          <= '0;
      held_valid_q    <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rate_cfg_q <= rate_q16_i;
      end
      if (cmd_i.start_chunk) begin
        chunk_rate_q    <= rate_clamp;
        chunk_off_q     <= (rate_cfg_q <= RATE_OFF_MAX);
        prev_q          <= sample_q;
        phase_q         <= '0;
        held_valid_q    <= 1'b0;
        first_pending_q <= last_q;
      end
      if (cmd_i.skip) begin
        prev_q <= sample_q;
        if (last_q) begin
          first_pending_q <= 1'b1;
        end
      end
      if (cmd_i.step_done) begin
        phase_q <= phase_q - Q_ONE;
        prev_q  <= sample_q;
      end
      if (cmd_i.round) begin
        phase_q <= sum_pr[RATE_W-1:0];
        if (delay) begin
          held_valid_q <= 1'b1;
        end
      end
      if (cmd_i.flush) begin
        held_valid_q    <= 1'b0;
        phase_q         <= '0;
        prev_q          <= sample_q;
        first_pending_q <= 1'b1;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sample_q <= sample_in_i;
      last_q   <= last_in_i;
    end
    if (cmd_i.mul) begin
      num_q <= base + prod;
    end
    if (cmd_i.round && delay) begin
      held_value_q <= interp_v;
    end
    if (push) begin
      out_sample_q <= push_val;
      out_last_q   <= push_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign last_out_o   = out_last_q;

  `LIR_ASSERT_NOW(a_push_free, push, out_free, "item pushed onto a full output register")
  `LIR_ASSERT_NEXT(a_flush_clear, cmd_i.flush, !held_valid_q, "held item survived flush")
  `LIR_ASSERT_NOW(a_phase_range, !first_pending_q, phase_q < 18'd196608,
                  "phase beyond three samples")

endmodule

`default_nettype wire

// ----- src/linear_interp_resampler.sv -----
// Linear interpolation sample-rate converter, top level.
// Input channel: in_valid_i/in_ready_o carry one signed 16-bit sample
// (sample_in_i) with last_in_i marking the final sample of a chunk.
// Output channel: out_valid_o/out_ready_i carry interpolated samples
// (sample_out_o) with last_out_o on the final output of a chunk.
// rate_q16_i is written by cfg_we_i; the user must write it only while idle,
// as the block itself does not enforce this. It is sampled as unsigned Q16
// when the first sample of a chunk arrives and holds for that chunk.
// Sequence: an item is taken in idle and decoded in the next cycle. Each
// output then takes a multiply step and a round-and-saturate step, one more
// decode follows the last of them, and an end-of-chunk release follows the
// last output of a chunk. One multiplier is shared by all outputs, and there
// is a single output register. The input is ready again in the first cycle
// the controller is back in idle.
// Above a rate of 1.0, and while the last sample of a chunk is processed,
// the newest output is held back one step so the last flag can be placed
// on it. A stalled receiver stops the controller at the next push; the
// pending item stays in the output register unchanged.
// Reset returns to idle with rate 1.0, awaiting the first sample of a chunk.
`default_nettype none

module linear_interp_resampler import lir_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic        [RATE_W-1:0]   rate_q16_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_in_i,
  input  wire logic                       last_in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0]      sample_out_o,
  output logic                            last_out_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  lir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  lir_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .rate_q16_i   (rate_q16_i),
    .sample_in_i  (sample_in_i),
    .last_in_i    (last_in_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .sample_out_o (sample_out_o),
    .last_out_o   (last_out_o)
  );

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// self-checking testbench: random and directed chunks through the resampler, checked against a predictor
module tb_top import lir_pkg::*; ();

  localparam int unsigned UNITY_Q16      = 65536;
  localparam int unsigned RATE_MUTE_MAX  = 655;
  localparam int unsigned RATE_FLOOR     = 2048;
  localparam int unsigned RATE_CEIL      = 131072;
  localparam int          SETTLE_CYCLES  = 160;
  localparam int          DRAIN_LIMIT    = 40000;
  localparam int          ACTIVE_TARGET  = 520;
  localparam int          QUIET_TAIL     = 440;
  localparam longint      TIMEOUT_CYCLES = 1200000;

  // one output item as seen on the output channel
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } out_item_t;

  // predicts resampled output items and checks them in order
  class resample_scoreboard;
    logic [RATE_W-1:0]          rate_reg;
    logic signed [SAMPLE_W-1:0] prev_sample;
    int unsigned                phase;
    bit                         first_pending;
    int unsigned                chunk_rate;
    bit                         chunk_off;
    bit                         held_valid;
    logic signed [SAMPLE_W-1:0] held_value;
    out_item_t                  expected_q[$];
    int errors;
    int results_seen;
    int items_seen;
    int active_items;
    int chunks_seen;

    function new();
      rate_reg      = RATE_W'(UNITY_Q16);
      prev_sample   = '0;
      phase         = 0;
      first_pending = 1'b1;
      chunk_rate    = UNITY_Q16;
      chunk_off     = 1'b0;
      held_valid    = 1'b0;
      held_value    = '0;
      errors        = 0;
      results_seen  = 0;
      items_seen    = 0;
      active_items  = 0;
      chunks_seen   = 0;
    endfunction

    function void set_rate(logic [RATE_W-1:0] value);
      rate_reg = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void discard();
      expected_q.delete();
    endfunction

    // linear blend of two samples at q16 offset f, truncated and saturated
    function logic signed [SAMPLE_W-1:0] blend(logic signed [SAMPLE_W-1:0] a,
                                               logic signed [SAMPLE_W-1:0] b,
                                               int unsigned f);
      longint num;
      longint quo;
      num = longint'(a) * (longint'(UNITY_Q16) - longint'(f)) + longint'(b) * longint'(f);
      quo = num / 65536;
      if (quo > 32767) quo = 32767;
      if (quo < -32768) quo = -32768;
      return quo[SAMPLE_W-1:0];
    endfunction

    function void push(logic signed [SAMPLE_W-1:0] value, logic is_last);
      out_item_t item;
      item.sample = value;
      item.last   = is_last;
      expected_q.push_back(item);
    endfunction

    // advance the predictor by one accepted source item
    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic is_last);
      int unsigned r;
      logic signed [SAMPLE_W-1:0] v;
      items_seen++;
      if (is_last) chunks_seen++;
      // first item of a chunk latches and clamps the rate
      if (first_pending) begin
        r = 32'(rate_reg);
        chunk_off = (r <= RATE_MUTE_MAX);
        if (r < RATE_FLOOR) r = RATE_FLOOR;
        if (r > RATE_CEIL) r = RATE_CEIL;
        chunk_rate    = r;
        prev_sample   = s;
        phase         = 0;
        held_valid    = 1'b0;
        first_pending = 1'b0;
        if (!chunk_off) active_items++;
        if (is_last) begin
          first_pending = 1'b1;
          if (!chunk_off) push(s, 1'b1);
        end
        return;
      end
      // muted chunk swallows its items
      if (chunk_off) begin
        prev_sample = s;
        if (is_last) first_pending = 1'b1;
        return;
      end
      active_items++;
      // mid-chunk: emit every position before this sample
      if (!is_last) begin
        while (phase < UNITY_Q16) begin
          v = blend(prev_sample, s, phase);
          phase += chunk_rate;
          if (chunk_rate > UNITY_Q16) begin
            if (held_valid) push(held_value, 1'b0);
            held_value = v;
            held_valid = 1'b1;
          end else begin
            push(v, 1'b0);
          end
        end
        phase -= UNITY_Q16;
        prev_sample = s;
        return;
      end
      // end of chunk: extrapolate up to the last fitting position
      while (phase + chunk_rate <= 2 * UNITY_Q16) begin
        v = blend(prev_sample, s, phase);
        if (held_valid) push(held_value, 1'b0);
        held_value = v;
        held_valid = 1'b1;
        phase += chunk_rate;
      end
      if (held_valid) push(held_value, 1'b1);
      held_valid    = 1'b0;
      phase         = 0;
      prev_sample   = s;
      first_pending = 1'b1;
    endfunction

    // compare one output item with the oldest prediction
    function void check_output(logic [SAMPLE_W-1:0] s, logic is_last);
      out_item_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected output item: sample_out %0d last_out %0d", $signed(s), is_last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (s !== want.sample) begin
        $error("sample_out: expected %0d, got %0d", $signed(want.sample), $signed(s));
        errors++;
      end
      if (is_last !== want.last) begin
        $error("last_out: expected %0d, got %0d", want.last, is_last);
        errors++;
      end
    endfunction
  endclass

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       cfg_we     = 1'b0;
  logic [RATE_W-1:0]          rate_cfg   = RATE_W'(UNITY_Q16);
  logic                       in_valid   = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_in  = '0;
  logic                       last_in    = 1'b0;
  logic                       out_valid;
  logic                       out_ready  = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       last_out;

  resample_scoreboard sb;
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  int stall_left = 0;
  int rate_writes = 0;

  linear_interp_resampler dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .rate_q16_i   (rate_cfg),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .sample_in_i  (sample_in),
    .last_in_i    (last_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .sample_out_o (sample_out),
    .last_out_o   (last_out)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // output monitor and receiver stalls in bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_output(sample_out, last_out);
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // hands one source item to the block, with an optional gap first
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic is_last);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= value;
    last_in   <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(value, is_last);
  endtask

  // hold the input until all predicted items are out, then let the block go quiet
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0) begin
      $error("%0d expected output items never arrived", sb.pending());
      sb.errors++;
      sb.discard();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // rate write, only once the block is idle
  task automatic write_rate(input logic [RATE_W-1:0] value);
    settle();
    cfg_we   <= 1'b1;
    rate_cfg <= value;
    @(posedge clk);
    sb.set_rate(value);
    rate_writes++;
    cfg_we <= 1'b0;
  endtask

  // source sample mix: full range, extremes and small values
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: begin
        raw = $urandom_range(0, 63) - 32;
        return raw[SAMPLE_W-1:0];
      end
      default: return raw[SAMPLE_W-1:0];
    endcase
  endfunction

  // watchdog
  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("linear_interp_resampler verification failed");
    $finish;
  end

  // main sequence
  initial begin
    logic [RATE_W-1:0] rate;
    int n_chunks;
    int len;
    bit leave_open;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset rate, one-sample chunks at the extremes, then a plain chunk
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sd1, 1'b1);
    // highest rate, alternating extremes
    write_rate(RATE_W'(RATE_CEIL));
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    // lowest rate, extrapolation past the last sample saturates
    write_rate(RATE_W'(RATE_FLOOR));
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    // tiny rate mutes the chunk, one-sample chunk too
    write_rate(RATE_W'(RATE_MUTE_MAX));
    send_sample(16'sd1234, 1'b1);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd7, 1'b1);
    // just above the mute limit is raised to the floor
    write_rate(RATE_W'(RATE_MUTE_MAX + 1));
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b1);
    // largest register value is lowered to the ceiling
    write_rate({RATE_W{1'b1}});
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh0000, 1'b1);
    // zero rate
    write_rate('0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b1);
    // rate change inside an open chunk must not apply until the next chunk
    write_rate(RATE_W'(98304));
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    write_rate(RATE_W'(32768));
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh0000, 1'b1);

    // random phases: new rate, then a few chunks, sometimes one left open
    while (sb.active_items < ACTIVE_TARGET) begin
      case ($urandom_range(0, 19))
        0: rate = RATE_W'($urandom_range(0, RATE_MUTE_MAX));
        1: rate = RATE_W'($urandom_range(RATE_MUTE_MAX + 1, RATE_FLOOR - 1));
        2: rate = RATE_W'($urandom_range(RATE_CEIL + 1, (1 << RATE_W) - 1));
        3: begin
          case ($urandom_range(0, 2))
            0: rate = RATE_W'(RATE_FLOOR);
            1: rate = RATE_W'(RATE_CEIL);
            default: rate = RATE_W'(UNITY_Q16);
          endcase
        end
        4, 5: rate = RATE_W'($urandom_range(RATE_FLOOR, 16384));
        default: rate = RATE_W'($urandom_range(16384, RATE_CEIL));
      endcase
      write_rate(rate);
      tx_idle_on = (sb.active_items < QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (sb.active_items < QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      n_chunks   = $urandom_range(1, 3);
      leave_open = ($urandom_range(0, 7) == 0);
      for (int c = 0; c < n_chunks; c++) begin
        len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
        for (int i = 0; i < len; i++) begin
          send_sample(pick_sample(),
                      (i == len - 1) && !(leave_open && c == n_chunks - 1));
        end
      end
    end

    // close any chunk still open, then drain
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    if (!sb.first_pending) send_sample(pick_sample(), 1'b1);
    settle();

    $display("covered %0d source items (%0d in live chunks) over %0d chunks and %0d rate writes,",
             sb.items_seen, sb.active_items, sb.chunks_seen, rate_writes);
    $display("including muted, clamped and extreme rates; %0d output items checked",
             sb.results_seen);
    if (sb.errors == 0) begin
      $display("linear_interp_resampler verification clean");
    end else begin
      $display("linear_interp_resampler verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/lir_pkg.sv
src/lir_ctrl.sv
src/lir_dpath.sv
src/linear_interp_resampler.sv
bench/tb_top.sv
